>>> hdl/tas_pkg.sv
`default_nettype none

package tas_pkg;

  localparam int NUM_LEVELS    = 3;
  localparam int MAX_PROCS_DEF = 64;
  localparam int ID_W          = 6;
  localparam int LVL_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int QUANTUM_W     = 8;

  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 8'd10;
  localparam logic                 AGING_RST   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_QUANTUM = 1'b0;
  localparam logic CFG_AGING   = 1'b1;

  // One queue update per cycle: an optional push and an optional pop.
  typedef struct packed {
    logic             push_en;
    logic [LVL_W-1:0] push_lvl;
    logic             pop_en;
    logic [LVL_W-1:0] pop_lvl;
  } tas_qop_t;

  // Occupancy flags of the three queues, one bit per level.
  typedef struct packed {
    logic [NUM_LEVELS-1:0] empty;
    logic [NUM_LEVELS-1:0] full;
  } tas_qflags_t;

endpackage

`default_nettype wire

>>> hdl/tas_ram.sv
`default_nettype none

module tas_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/tas_queues.sv
`default_nettype none

module tas_queues
  import tas_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  localparam int AW = $clog2(NUM_LEVELS * MAX_PROCS)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire tas_qop_t    op_i,
  output tas_qflags_t      flags_o,
  output logic [AW-1:0]    head_addr_o [NUM_LEVELS],
  output logic [AW-1:0]    tail_addr_o [NUM_LEVELS]
);

  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int SW = CW + 1;

  logic [PW-1:0] head_q [NUM_LEVELS];
  logic [CW-1:0] cnt_q  [NUM_LEVELS];
  logic [SW-1:0] tail_sum [NUM_LEVELS];
  logic [SW-1:0] tail_wrap [NUM_LEVELS];

  // Each level owns a contiguous window of the memory; the tail slot wraps
  // with a single compare because head plus count stays below twice the depth.
  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      tail_sum[l] = SW'(head_q[l]) + SW'(cnt_q[l]);
      if (tail_sum[l] >= SW'(MAX_PROCS)) begin
        tail_wrap[l] = tail_sum[l] - SW'(MAX_PROCS);
      end else begin
        tail_wrap[l] = tail_sum[l];
      end
      head_addr_o[l]   = AW'(l * MAX_PROCS) + AW'(head_q[l]);
      tail_addr_o[l]   = AW'(l * MAX_PROCS) + AW'(tail_wrap[l][PW-1:0]);
      flags_o.empty[l] = (cnt_q[l] == '0);
      flags_o.full[l]  = (cnt_q[l] == CW'(MAX_PROCS));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (op_i.pop_en && op_i.pop_lvl == LVL_W'(l)) begin
          if (head_q[l] == PW'(MAX_PROCS - 1)) begin
            head_q[l] <= '0;
          end else begin
            head_q[l] <= head_q[l] + 1'b1;
          end
        end
        if (op_i.push_en && op_i.push_lvl == LVL_W'(l) &&
            !(op_i.pop_en && op_i.pop_lvl == LVL_W'(l))) begin
          cnt_q[l] <= cnt_q[l] + 1'b1;
        end else if (op_i.pop_en && op_i.pop_lvl == LVL_W'(l) &&
                     !(op_i.push_en && op_i.push_lvl == LVL_W'(l))) begin
          cnt_q[l] <= cnt_q[l] - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/three_level_aging_scheduler.sv
// Flow: a make-ready item goes through the push step to the done step; a reschedule walks
// the steps of the queue sequencer (aging moves, re-queue, pop) before the done step.
// Throughput: one item at a time; the next item is accepted the cycle after the result enters
// the output register. A result held at the output stalls the sequencer in its last step.
// Reset (rst_ni, asynchronous, active low): all queues empty, countdowns and quantum at 10,
// aging on, nothing running; the queue memory itself is not cleared and needs no sweep.
`default_nettype none

module three_level_aging_scheduler
  import tas_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_addr_i,
  input  wire logic [QUANTUM_W-1:0] cfg_wdata_i,
  // Request channel.
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 req_type_i,
  input  wire logic [ID_W-1:0]      proc_id_i,
  input  wire logic [LVL_W-1:0]     proc_level_i,
  input  wire logic                 still_runnable_i,
  // Result channel.
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ID_W-1:0]           next_id_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int DEPTH = NUM_LEVELS * MAX_PROCS;
  localparam int AW    = $clog2(DEPTH);

  // The sequencer walks one reschedule through its steps. The memory is either
  // read or written in any one cycle, never both, and a write is always
  // committed before a later read of the same entry is issued, so no bypass
  // path is needed.
  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_AGE_MED,
    S_MOVE_MH,
    S_AGE_LOW,
    S_MOVE_LM,
    S_REQUEUE,
    S_POP,
    S_POP_DATA,
    S_DONE
  } state_e;

  state_e                state_q;

  // Configuration registers.
  logic [QUANTUM_W-1:0]  quantum_q;
  logic                  aging_q;

  // Aging countdowns and the running process.
  logic [QUANTUM_W-1:0]  med_cd_q;
  logic [QUANTUM_W-1:0]  low_cd_q;
  logic [QUANTUM_W-1:0]  med_cd_dec;
  logic [ID_W-1:0]       run_id_q;
  logic                  run_valid_q;

  // Fields of the item in progress.
  logic                  req_q;
  logic [ID_W-1:0]       pid_q;
  logic [LVL_W-1:0]      lvl_q;
  logic                  runnable_q;
  logic [STATUS_W-1:0]   st_q;

  // Output register.
  logic                  out_valid_q;
  logic [ID_W-1:0]       out_id_q;
  logic [STATUS_W-1:0]   out_st_q;

  // Queue bookkeeping and memory ports.
  tas_qop_t              qop;
  tas_qflags_t           flags;
  logic [AW-1:0]         head_addr [NUM_LEVELS];
  logic [AW-1:0]         tail_addr [NUM_LEVELS];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ID_W-1:0]       mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [ID_W-1:0]       mem_rdata;

  logic                  move_mh_ok;
  logic                  move_lm_ok;
  logic                  any_ready;
  logic [LVL_W-1:0]      pop_lvl;
  logic                  requeue;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign next_id_o   = out_id_q;
  assign status_o    = out_st_q;

  assign med_cd_dec = med_cd_q - 1'b1;

  // An aging move needs a head in the source queue and room in the target.
  assign move_mh_ok = !flags.empty[LVL_MED] && !flags.full[LVL_HIGH];
  assign move_lm_ok = !flags.empty[LVL_LOW] && !flags.full[LVL_MED];
  assign any_ready  = !(&flags.empty);
  assign requeue    = run_valid_q && runnable_q;

  // The highest non-empty level wins the dequeue.
  always_comb begin
    if (!flags.empty[LVL_HIGH]) begin
      pop_lvl = LVL_HIGH;
    end else if (!flags.empty[LVL_MED]) begin
      pop_lvl = LVL_MED;
    end else begin
      pop_lvl = LVL_LOW;
    end
  end

  // Memory and queue commands for the current step.
  always_comb begin
    qop       = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_PUSH: begin
        if (!flags.full[lvl_q]) begin
          mem_we       = 1'b1;
          mem_waddr    = tail_addr[lvl_q];
          mem_wdata    = pid_q;
          qop.push_en  = 1'b1;
          qop.push_lvl = lvl_q;
        end
      end
      S_AGE_MED: begin
        if (med_cd_dec == '0 && move_mh_ok) begin
          mem_re    = 1'b1;
          mem_raddr = head_addr[LVL_MED];
        end
      end
      S_MOVE_MH: begin
        mem_we       = 1'b1;
        mem_waddr    = tail_addr[LVL_HIGH];
        mem_wdata    = mem_rdata;
        qop.pop_en   = 1'b1;
        qop.pop_lvl  = LVL_MED;
        qop.push_en  = 1'b1;
        qop.push_lvl = LVL_HIGH;
      end
      S_AGE_LOW: begin
        if (low_cd_q == '0 && move_lm_ok) begin
          mem_re    = 1'b1;
          mem_raddr = head_addr[LVL_LOW];
        end
      end
      S_MOVE_LM: begin
        mem_we       = 1'b1;
        mem_waddr    = tail_addr[LVL_MED];
        mem_wdata    = mem_rdata;
        qop.pop_en   = 1'b1;
        qop.pop_lvl  = LVL_LOW;
        qop.push_en  = 1'b1;
        qop.push_lvl = LVL_MED;
      end
      S_REQUEUE: begin
        if (requeue && !flags.full[lvl_q]) begin
          mem_we       = 1'b1;
          mem_waddr    = tail_addr[lvl_q];
          mem_wdata    = run_id_q;
          qop.push_en  = 1'b1;
          qop.push_lvl = lvl_q;
        end
      end
      S_POP: begin
        if (any_ready) begin
          mem_re      = 1'b1;
          mem_raddr   = head_addr[pop_lvl];
          qop.pop_en  = 1'b1;
          qop.pop_lvl = pop_lvl;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RST;
      aging_q   <= AGING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_QUANTUM: quantum_q <= cfg_wdata_i;
        CFG_AGING:   aging_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, scheduler state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      med_cd_q    <= QUANTUM_RST;
      low_cd_q    <= QUANTUM_RST;
      run_id_q    <= '0;
      run_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      req_q       <= 1'b0;
      pid_q       <= '0;
      lvl_q       <= LVL_LOW;
      runnable_q  <= 1'b0;
      st_q        <= ST_OK;
      out_id_q    <= '0;
      out_st_q    <= ST_OK;
    end else begin
      // The last step refills the output register itself.
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q      <= req_type_i;
            pid_q      <= proc_id_i;
            // Level three is served as the high level.
            lvl_q      <= (proc_level_i == 2'd3) ? LVL_HIGH : proc_level_i;
            runnable_q <= still_runnable_i;
            st_q       <= ST_OK;
            if (req_type_i) begin
              state_q <= S_PUSH;
            end else if (aging_q) begin
              state_q <= S_AGE_MED;
            end else begin
              state_q <= S_REQUEUE;
            end
          end
        end
        S_PUSH: begin
          if (flags.full[lvl_q]) begin
            st_q <= ST_FULL;
          end
          state_q <= S_DONE;
        end
        S_AGE_MED: begin
          if (med_cd_dec == '0) begin
            med_cd_q <= quantum_q;
            low_cd_q <= low_cd_q - 1'b1;
            state_q  <= move_mh_ok ? S_MOVE_MH : S_AGE_LOW;
          end else begin
            med_cd_q <= med_cd_dec;
            state_q  <= S_AGE_LOW;
          end
        end
        S_MOVE_MH: begin
          state_q <= S_AGE_LOW;
        end
        S_AGE_LOW: begin
          if (low_cd_q == '0) begin
            low_cd_q <= quantum_q;
            state_q  <= move_lm_ok ? S_MOVE_LM : S_REQUEUE;
          end else begin
            state_q <= S_REQUEUE;
          end
        end
        S_MOVE_LM: begin
          state_q <= S_REQUEUE;
        end
        S_REQUEUE: begin
          if (requeue && flags.full[lvl_q]) begin
            st_q <= ST_FULL;
          end
          state_q <= S_POP;
        end
        S_POP: begin
          if (any_ready) begin
            state_q <= S_POP_DATA;
          end else begin
            st_q        <= ST_NONE;
            run_valid_q <= 1'b0;
            state_q     <= S_DONE;
          end
        end
        S_POP_DATA: begin
          run_id_q    <= mem_rdata;
          run_valid_q <= 1'b1;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_st_q    <= st_q;
            // Only a reschedule that found a process reports an id.
            out_id_q    <= (!req_q && st_q != ST_NONE) ? run_id_q : '0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  tas_queues #(
    .MAX_PROCS (MAX_PROCS)
  ) u_queues (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (qop),
    .flags_o     (flags),
    .head_addr_o (head_addr),
    .tail_addr_o (tail_addr)
  );

  tas_ram #(
    .WIDTH (ID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/tas_chk.sv
`default_nettype none

module tas_chk
  import tas_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic [ID_W-1:0]     next_id_o,
  input wire logic [STATUS_W-1:0] status_o
);

  // A result waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(next_id_o) && $stable(status_o))
    else $error("stalled result changed");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in progress");

  // An empty scheduler reports no process id.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_NONE |-> next_id_o == '0)
    else $error("none-ready result carries a process id");

endmodule

bind three_level_aging_scheduler tas_chk u_tas_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .next_id_o   (next_id_o),
  .status_o    (status_o)
);

`default_nettype wire
